// ===== hdl/tea_pkg.sv =====
package tea_pkg;

    localparam logic [31:0] DELTA      = 32'h9e3779b9;
    localparam logic [6:0]  MAX_ROUNDS = 7'd64;
    localparam logic [6:0]  ROUNDS_RST = 7'd32;

    localparam int          ADDR_W     = 5;
    localparam logic [2:0]  REG_KEY0   = 3'd0;
    localparam logic [2:0]  REG_KEY1   = 3'd1;
    localparam logic [2:0]  REG_KEY2   = 3'd2;
    localparam logic [2:0]  REG_KEY3   = 3'd3;
    localparam logic [2:0]  REG_ROUNDS = 3'd4;

    typedef struct packed {
        logic        func;
        logic [31:0] first_half;
        logic [31:0] second_half;
    } in_t;

    typedef struct packed {
        logic [31:0] first_half_out;
        logic [31:0] second_half_out;
    } out_t;

    typedef struct packed {
        logic [31:0] key_word0;
        logic [31:0] key_word1;
        logic [31:0] key_word2;
        logic [31:0] key_word3;
        logic [6:0]  round_count;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       out_load;
        logic [6:0] rounds;
    } cmd_t;

    function automatic logic [31:0] tea_mix(
        input logic [31:0] x,
        input logic [31:0] s,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
    endfunction

endpackage

// ===== hdl/tea_block_cipher_top.sv =====
// an accepted item is loaded, then runs n rounds, n = round count capped at 64, and
// then moves its result into the result register once that is free (a round count of zero
// skips the rounds); one feistel cycle per clock in the round datapath; new items are taken
// only when idle; the result register frees the engine for the next item while a result waits
// reset: asynchronous active low, keys clear to zero and round count to 32
module tea_block_cipher_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tea_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  tea_pkg::in_t               in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output tea_pkg::out_t              out_data
);
    import tea_pkg::*;

    cfg_t cfg;
    cmd_t cmd;

    tea_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tea_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .round_count (cfg.round_count),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd)
    );

    tea_datapath u_dp (
        .clk      (clk),
        .cfg      (cfg),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

// ===== hdl/tea_cfg_regs.sv =====
module tea_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tea_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output tea_pkg::cfg_t             cfg
);
    import tea_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] index;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_KEY0:   cfg_next.key_word0   = pwdata;
                REG_KEY1:   cfg_next.key_word1   = pwdata;
                REG_KEY2:   cfg_next.key_word2   = pwdata;
                REG_KEY3:   cfg_next.key_word3   = pwdata;
                REG_ROUNDS: cfg_next.round_count = pwdata[6:0];
                default:    cfg_next             = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_KEY0:   prdata = cfg_reg.key_word0;
            REG_KEY1:   prdata = cfg_reg.key_word1;
            REG_KEY2:   prdata = cfg_reg.key_word2;
            REG_KEY3:   prdata = cfg_reg.key_word3;
            REG_ROUNDS: prdata = {25'd0, cfg_reg.round_count};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_word0   <= 32'd0;
            cfg_reg.key_word1   <= 32'd0;
            cfg_reg.key_word2   <= 32'd0;
            cfg_reg.key_word3   <= 32'd0;
            cfg_reg.round_count <= ROUNDS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/tea_ctrl.sv =====
module tea_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [6:0]    round_count,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output tea_pkg::cmd_t cmd
);
    import tea_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [6:0] count_reg;
    logic [6:0] count_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [6:0] eff_rounds;
    logic       in_accept;
    logic       out_free;

    assign eff_rounds = (round_count > MAX_ROUNDS) ? MAX_ROUNDS : round_count;
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.out_load = 1'b0;
        cmd.rounds   = eff_rounds;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cmd.load   = 1'b1;
                    count_next = eff_rounds;
                    state_next = (eff_rounds == 7'd0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step   = 1'b1;
                count_next = count_reg - 7'd1;
                if (count_reg == 7'd1)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= 7'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (count_reg != 7'd0 && count_reg <= MAX_ROUNDS))
        else $error("round counter out of range while running");

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while held");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != ST_IDLE))
        else $error("engine idle right after taking an item");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> out_valid_reg)
        else $error("finished block not presented");
`endif

endmodule

// ===== hdl/tea_datapath.sv =====
module tea_datapath (
    input  logic          clk,
    input  tea_pkg::cfg_t cfg,
    input  tea_pkg::cmd_t cmd,
    input  tea_pkg::in_t  in_data,
    output tea_pkg::out_t out_data
);
    import tea_pkg::*;

    logic [31:0] a_reg;
    logic [31:0] a_next;
    logic [31:0] b_reg;
    logic [31:0] b_next;
    logic [31:0] s_reg;
    logic [31:0] s_next;
    logic        dec_reg;
    logic        dec_next;
    out_t        out_reg;
    out_t        out_next;
    logic [31:0] start_sum;
    logic [31:0] enc_a;
    logic [31:0] enc_b;
    logic [31:0] dec_a;
    logic [31:0] dec_b;

    assign start_sum = DELTA * {25'd0, cmd.rounds};

    // one full feistel cycle per clock
    assign enc_a = a_reg + tea_mix(b_reg, s_reg, cfg.key_word0, cfg.key_word1);
    assign enc_b = b_reg + tea_mix(enc_a, s_reg, cfg.key_word2, cfg.key_word3);
    assign dec_b = b_reg - tea_mix(a_reg, s_reg, cfg.key_word2, cfg.key_word3);
    assign dec_a = a_reg - tea_mix(dec_b, s_reg, cfg.key_word0, cfg.key_word1);

    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        s_next   = s_reg;
        dec_next = dec_reg;
        priority if (cmd.load)
        begin
            a_next   = in_data.first_half;
            b_next   = in_data.second_half;
            dec_next = in_data.func;
            s_next   = in_data.func ? start_sum : DELTA;
        end
        else if (cmd.step)
        begin
            a_next = dec_reg ? dec_a : enc_a;
            b_next = dec_reg ? dec_b : enc_b;
            s_next = dec_reg ? (s_reg - DELTA) : (s_reg + DELTA);
        end
    end

    always_comb
    begin
        out_next = out_reg;
        if (cmd.out_load)
        begin
            out_next.first_half_out  = a_reg;
            out_next.second_half_out = b_reg;
        end
    end

    assign out_data = out_reg;

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        s_reg   <= s_next;
        dec_reg <= dec_next;
        out_reg <= out_next;
    end

endmodule
